>>> rtl/core/tpc_pkg.sv
// Shared widths, codes and constant tables of the tilt posture classifier.
package tpc_pkg;

    localparam int ACC_W     = 16;
    localparam int LIGHT_W   = 12;
    localparam int THR_W     = 13;
    localparam int ANG_W     = 15;
    localparam int SQ_IN_W   = 58;
    localparam int SQ_OUT_W  = 29;
    localparam int SQ_REM_W  = 33;
    localparam int DIV_NUM_W = 38;
    localparam int DIV_DEN_W = 24;
    localparam int TURN_W    = 22;
    localparam int RECIP_SH  = 27;

    localparam logic signed [15:0] UNIT_ONE    = 16'sd16384;
    localparam logic signed [31:0] DOT_ONE     = 32'sd268435456;
    localparam logic [SQ_IN_W-1:0] DOT_ONE_SQ  = 58'h100_0000_0000_0000;
    localparam logic [19:0]        ANGLE_MAX   = 20'd900000;
    localparam logic [19:0]        ROUND_HALF  = 20'd50;
    localparam logic [20:0]        CD_RECIP    = 21'd1342178;
    localparam logic [ANG_W-1:0]   RIGHT_ANGLE = 15'd9000;
    localparam logic [ANG_W-1:0]   STRAIGHT    = 15'd18000;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CAL     = 1'b1;

    localparam logic [1:0] REG_UPRIGHT  = 2'd0;
    localparam logic [1:0] REG_SLIGHT   = 2'd1;
    localparam logic [1:0] REG_MODERATE = 2'd2;
    localparam logic [1:0] REG_MARGIN   = 2'd3;

    localparam logic [1:0] CLASS_UPRIGHT  = 2'd0;
    localparam logic [1:0] CLASS_SLIGHT   = 2'd1;
    localparam logic [1:0] CLASS_MODERATE = 2'd2;
    localparam logic [1:0] CLASS_HEAVY    = 2'd3;

    function automatic logic [19:0] atan_entry(input logic [3:0] i);
        logic [19:0] v;
        case (i)
            4'd0:    v = 20'd450000;
            4'd1:    v = 20'd265651;
            4'd2:    v = 20'd140362;
            4'd3:    v = 20'd71250;
            4'd4:    v = 20'd35763;
            4'd5:    v = 20'd17899;
            4'd6:    v = 20'd8952;
            4'd7:    v = 20'd4476;
            4'd8:    v = 20'd2238;
            4'd9:    v = 20'd1119;
            4'd10:   v = 20'd560;
            4'd11:   v = 20'd280;
            4'd12:   v = 20'd140;
            4'd13:   v = 20'd70;
            4'd14:   v = 20'd35;
            default: v = 20'd17;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/tpc_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module tpc_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpc_pkg::SQ_IN_W-1:0]   radicand,
    output logic                          done,
    output logic [tpc_pkg::SQ_OUT_W-1:0]  root
);

    logic [tpc_pkg::SQ_IN_W-1:0]  op_reg;
    logic [tpc_pkg::SQ_REM_W-1:0] rem_reg;
    logic [tpc_pkg::SQ_OUT_W-1:0] root_reg;
    logic [4:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [tpc_pkg::SQ_REM_W-1:0] rem_sh;
    logic [tpc_pkg::SQ_REM_W-1:0] trial;
    logic                         ge;

    assign rem_sh = {rem_reg[tpc_pkg::SQ_REM_W-3:0], op_reg[tpc_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[tpc_pkg::SQ_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[tpc_pkg::SQ_OUT_W-2:0], ge};
            cnt_reg  <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(tpc_pkg::SQ_OUT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/core/tpc_div.sv
// Restoring divider, one quotient bit per cycle.
module tpc_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tpc_pkg::DIV_NUM_W-1:0]  num,
    input  logic [tpc_pkg::DIV_DEN_W-1:0]  den,
    output logic                           done,
    output logic [tpc_pkg::DIV_NUM_W-1:0]  quot
);

    logic [tpc_pkg::DIV_NUM_W-1:0] num_reg;
    logic [tpc_pkg::DIV_DEN_W-1:0] den_reg;
    logic [tpc_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [5:0]                    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [tpc_pkg::DIV_DEN_W:0]   rem_sh;
    logic [tpc_pkg::DIV_DEN_W:0]   diff;
    logic                          ge;

    assign rem_sh = {rem_reg, num_reg[tpc_pkg::DIV_NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign done   = done_reg;
    assign quot   = num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[tpc_pkg::DIV_DEN_W-1:0] : rem_sh[tpc_pkg::DIV_DEN_W-1:0];
            num_reg <= {num_reg[tpc_pkg::DIV_NUM_W-2:0], ge};
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(tpc_pkg::DIV_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/core/tilt_posture_classifier_top.sv
// Top level of the tilt posture classifier: sequencer, shared multiplier and CORDIC.
//
// Input stream (s_*): one beat carries an opcode in s_tuser, three signed accelerometer
// axes and a light reading in s_tdata. A calibrate beat stores the normalized sample as
// the reference and light plus margin as the light threshold, and answers with one result
// beat. A measure beat before calibration is dropped without a result.
// Output stream (m_*): one result beat per answered input beat, tilt angle in
// centidegrees, posture class and light reading in m_tdata, flags in m_tuser.
// Configuration: APB port, four registers at byte addresses 0, 4, 8 and 12.
// Timing: one beat at a time. The time a beat takes is set by the bit-serial square-root
// unit (29 steps, used twice in a measure beat), the bit-serial divider (38 steps, once
// per axis) and 16 CORDIC steps through one shift-add unit. A calibrate beat, or a
// measure beat against a zero reference, skips the second square root and the CORDIC;
// a zero sample skips the square roots and the divider as well.
// s_tready is high whenever the sequencer is idle; a finished result waits in the output
// register while the next beat is taken, and the sequencer holds its result until the
// output register is free when m_tready stays low.
// Reset: limits return to 500, 800, 1500 and margin to 300; the block is uncalibrated,
// the reference is zero and the light state is dark.
module tilt_posture_classifier_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // accel_x, accel_y, accel_z, light_level, zero pad
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tilt_centideg, posture_class, light_out, zero pad
    output logic [2:0]  m_tuser    // light_edge, calibration_event, bad_sample
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_MSQ  = 14'b00000000000010,
        S_SQM  = 14'b00000000000100,
        S_DIVS = 14'b00000000001000,
        S_DIVW = 14'b00000000010000,
        S_POST = 14'b00000000100000,
        S_DOT  = 14'b00000001000000,
        S_DSQ0 = 14'b00000010000000,
        S_DSQ1 = 14'b00000100000000,
        S_SQY  = 14'b00001000000000,
        S_COR  = 14'b00010000000000,
        S_ANG0 = 14'b00100000000000,
        S_ANG1 = 14'b01000000000000,
        S_FIN  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [14:0] upright_reg, slight_reg, moderate_reg;
    logic [11:0] margin_reg;
    logic        cfg_wr;

    logic signed [15:0] c_reg   [3];
    logic signed [15:0] u_reg   [3];
    logic signed [15:0] ref_reg [3];
    logic [11:0]        light_reg;
    logic               op_reg;
    logic [12:0]        thr_reg;
    logic               cal_reg;
    logic               dark_reg;
    logic               edge_reg;
    logic               bad_reg;
    logic [1:0]         idx_reg;
    logic               phase_reg;
    logic [31:0]        m2_reg;
    logic [23:0]        mag_reg;
    logic signed [31:0] dot_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [21:0] t_reg;
    logic [3:0]         ci_reg;
    logic [14:0]        tilt_reg;
    logic [1:0]         cls_reg;
    logic signed [59:0] prod_reg;

    logic        out_valid_reg;
    logic [14:0] out_tilt_reg;
    logic [1:0]  out_cls_reg;
    logic [11:0] out_light_reg;
    logic        out_edge_reg, out_cal_reg, out_bad_reg;

    logic signed [29:0] mul_a, mul_b;
    logic               sq_start, sq_done;
    logic [57:0]        sq_in;
    logic [28:0]        sq_root;
    logic               div_start, div_done;
    logic [37:0]        div_num;
    logic [37:0]        div_quot;

    logic               accept;
    logic               c_neg;
    logic [16:0]        abs_c;
    logic [31:0]        m2_sum;
    logic signed [31:0] dot_sum;
    logic [15:0]        q_clamp;
    logic               ref_zero;
    logic signed [31:0] sx, sy;
    logic signed [21:0] atan_v;
    logic [19:0]        t_round;
    logic [14:0]        cd;
    logic [14:0]        angle;
    logic [1:0]         cls;
    logic               dark_now;

    // APB registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            tpc_pkg::REG_UPRIGHT:  prdata = {17'd0, upright_reg};
            tpc_pkg::REG_SLIGHT:   prdata = {17'd0, slight_reg};
            tpc_pkg::REG_MODERATE: prdata = {17'd0, moderate_reg};
            tpc_pkg::REG_MARGIN:   prdata = {20'd0, margin_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upright_reg  <= 15'd500;
            slight_reg   <= 15'd800;
            moderate_reg <= 15'd1500;
            margin_reg   <= 12'd300;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                tpc_pkg::REG_UPRIGHT:  upright_reg  <= pwdata[14:0];
                tpc_pkg::REG_SLIGHT:   slight_reg   <= pwdata[14:0];
                tpc_pkg::REG_MODERATE: moderate_reg <= pwdata[14:0];
                tpc_pkg::REG_MARGIN:   margin_reg   <= pwdata[11:0];
                default:               margin_reg   <= margin_reg;
            endcase
        end
    end

    // shared units
    tpc_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    tpc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (mag_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign dark_now = {1'b0, s_tdata[59:48]} < thr_reg;

    assign c_neg    = c_reg[idx_reg][15];
    assign abs_c    = c_neg ? (17'd0 - {c_reg[idx_reg][15], c_reg[idx_reg]})
                            : {1'b0, c_reg[idx_reg]};
    assign div_num  = {abs_c[15:0], 22'd0} + {15'd0, mag_reg[23:1]};
    assign q_clamp  = (div_quot > 38'd16384) ? 16'd16384 : {1'b0, div_quot[14:0]};
    assign m2_sum   = m2_reg + prod_reg[31:0];
    assign dot_sum  = dot_reg + prod_reg[31:0];
    assign ref_zero = (ref_reg[0] == 16'sd0) && (ref_reg[1] == 16'sd0)
                      && (ref_reg[2] == 16'sd0);
    assign sx       = x_reg >>> ci_reg;
    assign sy       = y_reg >>> ci_reg;
    assign atan_v   = $signed({2'b00, tpc_pkg::atan_entry(ci_reg)});
    assign cd       = prod_reg[tpc_pkg::RECIP_SH+14:tpc_pkg::RECIP_SH];
    assign angle    = dot_reg[31] ? tpc_pkg::STRAIGHT - cd : cd;

    always_comb
    begin
        if (t_reg[21])
            t_round = tpc_pkg::ROUND_HALF;
        else if (t_reg[19:0] > tpc_pkg::ANGLE_MAX || t_reg[20])
            t_round = tpc_pkg::ANGLE_MAX + tpc_pkg::ROUND_HALF;
        else
            t_round = t_reg[19:0] + tpc_pkg::ROUND_HALF;
    end

    always_comb
    begin
        if (angle < upright_reg)
            cls = tpc_pkg::CLASS_UPRIGHT;
        else if (angle < slight_reg)
            cls = tpc_pkg::CLASS_SLIGHT;
        else if (angle < moderate_reg)
            cls = tpc_pkg::CLASS_MODERATE;
        else
            cls = tpc_pkg::CLASS_HEAVY;
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = 30'sd0;
        mul_b = 30'sd0;
        case (state_reg)
            S_MSQ:
            begin
                mul_a = 30'(c_reg[idx_reg]);
                mul_b = 30'(c_reg[idx_reg]);
            end
            S_DOT:
            begin
                mul_a = 30'(ref_reg[idx_reg]);
                mul_b = 30'(u_reg[idx_reg]);
            end
            S_DSQ0:
            begin
                mul_a = dot_reg[29:0];
                mul_b = dot_reg[29:0];
            end
            S_ANG0:
            begin
                mul_a = $signed({10'd0, t_round});
                mul_b = $signed({9'd0, tpc_pkg::CD_RECIP});
            end
            default:
            begin
                mul_a = 30'sd0;
                mul_b = 30'sd0;
            end
        endcase
    end

    assign sq_start  = ((state_reg == S_MSQ) && phase_reg && (idx_reg == 2'd2)
                        && (m2_sum != 32'd0)) || (state_reg == S_DSQ1);
    assign sq_in     = (state_reg == S_DSQ1) ? tpc_pkg::DOT_ONE_SQ - prod_reg[57:0]
                                             : {10'd0, m2_sum, 16'd0};
    assign div_start = (state_reg == S_DIVS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && (s_tuser[0] == tpc_pkg::OP_CAL || cal_reg))
                    state_next = S_MSQ;
            S_MSQ:
                if (phase_reg && idx_reg == 2'd2)
                    state_next = (m2_sum == 32'd0) ? S_POST : S_SQM;
            S_SQM:
                if (sq_done)
                    state_next = S_DIVS;
            S_DIVS:
                state_next = S_DIVW;
            S_DIVW:
                if (div_done)
                    state_next = (idx_reg == 2'd2) ? S_POST : S_DIVS;
            S_POST:
                if (op_reg == tpc_pkg::OP_CAL || bad_reg || ref_zero)
                    state_next = S_FIN;
                else
                    state_next = S_DOT;
            S_DOT:
                if (phase_reg && idx_reg == 2'd2)
                    state_next = S_DSQ0;
            S_DSQ0:
                state_next = S_DSQ1;
            S_DSQ1:
                state_next = S_SQY;
            S_SQY:
                if (sq_done)
                    state_next = S_COR;
            S_COR:
                if (ci_reg == 4'd15)
                    state_next = S_ANG0;
            S_ANG0:
                state_next = S_ANG1;
            S_ANG1:
                state_next = S_FIN;
            S_FIN:
                if (!out_valid_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cal_reg   <= 1'b0;
            dark_reg  <= 1'b1;
            thr_reg   <= '0;
            ref_reg   <= '{default: 16'sd0};
        end
        else
        begin
            state_reg <= state_next;
            if (accept && s_tuser[0] == tpc_pkg::OP_CAL)
            begin
                cal_reg <= 1'b1;
                thr_reg <= {1'b0, s_tdata[59:48]} + {1'b0, margin_reg};
            end
            else if (accept && cal_reg)
            begin
                dark_reg <= dark_now;
            end
            if (state_reg == S_POST && op_reg == tpc_pkg::OP_CAL)
                ref_reg <= u_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                c_reg[0]  <= $signed(s_tdata[15:0]);
                c_reg[1]  <= $signed(s_tdata[31:16]);
                c_reg[2]  <= $signed(s_tdata[47:32]);
                light_reg <= s_tdata[59:48];
                op_reg    <= s_tuser[0];
                edge_reg  <= (s_tuser[0] == tpc_pkg::OP_MEASURE) && !dark_now && dark_reg;
                bad_reg   <= 1'b0;
                idx_reg   <= 2'd0;
                phase_reg <= 1'b0;
                m2_reg    <= 32'd0;
            end
            S_MSQ:
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    m2_reg  <= m2_sum;
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd2 && m2_sum == 32'd0)
                    begin
                        bad_reg <= 1'b1;
                        u_reg   <= '{default: 16'sd0};
                    end
                end
            end
            S_SQM:
            begin
                mag_reg <= sq_root[23:0];
                idx_reg <= 2'd0;
            end
            S_DIVW:
                if (div_done)
                begin
                    u_reg[idx_reg] <= c_neg ? -$signed(q_clamp) : $signed(q_clamp);
                    idx_reg        <= idx_reg + 2'd1;
                end
            S_POST:
            begin
                idx_reg   <= 2'd0;
                phase_reg <= 1'b0;
                dot_reg   <= 32'sd0;
                if (op_reg == tpc_pkg::OP_CAL)
                begin
                    tilt_reg <= '0;
                    cls_reg  <= tpc_pkg::CLASS_UPRIGHT;
                end
                else
                begin
                    tilt_reg <= tpc_pkg::RIGHT_ANGLE;
                    cls_reg  <= tpc_pkg::CLASS_HEAVY;
                    if (ref_zero)
                        bad_reg <= 1'b1;
                end
            end
            S_DOT:
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg != 2'd2)
                        dot_reg <= dot_sum;
                    else if (dot_sum > tpc_pkg::DOT_ONE)
                        dot_reg <= tpc_pkg::DOT_ONE;
                    else if (dot_sum < -tpc_pkg::DOT_ONE)
                        dot_reg <= -tpc_pkg::DOT_ONE;
                    else
                        dot_reg <= dot_sum;
                end
            end
            S_SQY:
            begin
                x_reg  <= dot_reg[31] ? -dot_reg : dot_reg;
                y_reg  <= $signed({3'd0, sq_root});
                t_reg  <= 22'sd0;
                ci_reg <= 4'd0;
            end
            S_COR:
            begin
                ci_reg <= ci_reg + 4'd1;
                if (!y_reg[31])
                begin
                    x_reg <= x_reg + sy;
                    y_reg <= y_reg - sx;
                    t_reg <= t_reg + atan_v;
                end
                else
                begin
                    x_reg <= x_reg - sy;
                    y_reg <= y_reg + sx;
                    t_reg <= t_reg - atan_v;
                end
            end
            S_ANG1:
            begin
                tilt_reg <= angle;
                cls_reg  <= cls;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_FIN && (!out_valid_reg || m_tready))
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && (!out_valid_reg || m_tready))
        begin
            out_tilt_reg  <= tilt_reg;
            out_cls_reg   <= cls_reg;
            out_light_reg <= light_reg;
            out_edge_reg  <= edge_reg;
            out_cal_reg   <= op_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_light_reg, out_cls_reg, out_tilt_reg};
    assign m_tuser  = {out_bad_reg, out_cal_reg, out_edge_reg};

    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cal_reg |=> cal_reg)
        else $error("calibration flag dropped");

    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[14:0] <= tpc_pkg::STRAIGHT)
        else $error("tilt out of range");

    a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[16:0] == 17'd0 && !m_tuser[0]))
        else $error("calibration beat carries an angle or edge");

    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVS) |-> (mag_reg != 24'd0))
        else $error("divide by zero magnitude");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the tilt posture classifier: table plus random beats.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [14:0] tilt;
        logic [1:0]  cls;
        logic [11:0] light;
        logic        rise;
        logic        cal;
        logic        bad;
    } posture_t;

    typedef struct packed {
        logic        op;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [11:0] light;
        logic        typed;
        logic        has;
        posture_t    res;
    } vec_row_t;

    localparam int N_ROWS    = 21;
    localparam int WD_LIMIT  = 20000;
    localparam int SETTLE    = 300;
    localparam int HOLD_LONG = 1000;

    localparam vec_row_t TABLE [0:N_ROWS-1] = '{
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b1, 1'b0, '0},
        '{tpc_pkg::OP_CAL,     16'h0000, 16'h0000, 16'h0000, 12'd4095, 1'b1, 1'b1,
          '{15'd0, tpc_pkg::CLASS_UPRIGHT, 12'd4095, 1'b0, 1'b1, 1'b1}},
        '{tpc_pkg::OP_MEASURE, 16'd100,  16'h0000, 16'h0000, 12'd4095, 1'b1, 1'b1,
          '{15'd9000, tpc_pkg::CLASS_HEAVY, 12'd4095, 1'b0, 1'b0, 1'b1}},
        '{tpc_pkg::OP_CAL,     16'h0000, 16'h0000, 16'h4000, 12'd0,    1'b1, 1'b1,
          '{15'd0, tpc_pkg::CLASS_UPRIGHT, 12'd0, 1'b0, 1'b1, 1'b0}},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'h0000, 12'd4095, 1'b1, 1'b1,
          '{15'd9000, tpc_pkg::CLASS_HEAVY, 12'd4095, 1'b1, 1'b0, 1'b1}},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b1, 1'b1,
          '{15'd9000, tpc_pkg::CLASS_HEAVY, 12'd0, 1'b0, 1'b0, 1'b1}},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'h4000, 12'd299,  1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'hC000, 12'd300,  1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h4000, 16'h0000, 16'h0000, 12'd0,    1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'd301,  1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h8000, 16'h8000, 16'h8000, 12'd2048, 1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h0001, 16'h0000, 16'h0000, 12'd1,    1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'hFFFF, 16'h0001, 12'd4094, 1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'h7FFF, 12'd4095, 1'b0, 1'b1, '0},
        '{tpc_pkg::OP_CAL,     16'h8000, 16'h8000, 16'h8000, 12'd4095, 1'b1, 1'b1,
          '{15'd0, tpc_pkg::CLASS_UPRIGHT, 12'd4095, 1'b0, 1'b1, 1'b0}},
        '{tpc_pkg::OP_MEASURE, 16'h8000, 16'h8000, 16'h8000, 12'd4095, 1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'd0,    1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h8000, 16'h7FFF, 16'h0000, 12'd100,  1'b0, 1'b1, '0},
        '{tpc_pkg::OP_CAL,     16'h0000, 16'h0001, 16'h0000, 12'd0,    1'b1, 1'b1,
          '{15'd0, tpc_pkg::CLASS_UPRIGHT, 12'd0, 1'b0, 1'b1, 1'b0}},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'd300,  16'd10,   12'd5,    1'b0, 1'b1, '0},
        '{tpc_pkg::OP_MEASURE, 16'h0000, 16'd300,  16'd100,  12'd300,  1'b0, 1'b1, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // accel_x, accel_y, accel_z, light_level, zero pad
    logic [0:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // tilt_centideg, posture_class, light_out, zero pad
    logic [2:0]  m_tuser;   // light_edge, calibration_event, bad_sample

    posture_t    pending_q[$];
    int          mismatches;
    int          n_in;
    int          n_out;
    int          n_cfg;
    bit          quiet;
    bit          hold_req;
    int          idle_cycles;

    longint      ref_dir[3];
    int unsigned light_thr;
    bit          calibrated;
    bit          in_dark;
    int unsigned lim_up, lim_slight, lim_mod, margin;
    int          cal_raw[3];

    tilt_posture_classifier_top u_dut (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic unit_vector(input longint c[3], output longint u[3], output bit ok);
        longint unsigned m2;
        longint unsigned mag;
        longint unsigned a;
        longint          q;
        m2 = 0;
        for (int i = 0; i < 3; i++)
            m2 += longint'(c[i] * c[i]);
        ok = (m2 != 0);
        for (int i = 0; i < 3; i++)
            u[i] = 0;
        if (ok)
        begin
            mag = int_sqrt(m2 << 16);
            for (int i = 0; i < 3; i++)
            begin
                a = longint'(c[i] < 0 ? -c[i] : c[i]) << 22;
                q = longint'((a + mag / 2) / mag);
                if (q > 16384)
                    q = 16384;
                u[i] = c[i] < 0 ? -q : q;
            end
        end
    endtask

    function automatic int unsigned angle_cd(input longint d);
        longint x;
        longint y;
        longint t;
        longint nx;
        int unsigned cd;
        x = d < 0 ? -d : d;
        y = longint'(int_sqrt((64'd1 << 56) - longint'(d * d)));
        t = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                t += longint'(tpc_pkg::atan_entry(4'(i)));
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                t -= longint'(tpc_pkg::atan_entry(4'(i)));
            end
            x = nx;
        end
        if (t < 0)
            t = 0;
        if (t > 900000)
            t = 900000;
        cd = int'((t + 50) / 100);
        return d < 0 ? 18000 - cd : cd;
    endfunction

    task automatic predict_posture(input logic op, input logic [15:0] ax, ay, az,
                                   input logic [11:0] light, output bit has,
                                   output posture_t r);
        longint      c[3];
        longint      u[3];
        longint      d;
        bit          ok;
        bit          dark;
        int unsigned ang;
        c[0] = longint'($signed(ax));
        c[1] = longint'($signed(ay));
        c[2] = longint'($signed(az));
        r = '0;
        r.light = light;
        has = 1'b1;
        if (op == tpc_pkg::OP_CAL)
        begin
            unit_vector(c, ref_dir, ok);
            light_thr  = (light + margin) & 13'h1FFF;
            calibrated = 1'b1;
            r.cal = 1'b1;
            r.bad = !ok;
            cal_raw[0] = int'(c[0]);
            cal_raw[1] = int'(c[1]);
            cal_raw[2] = int'(c[2]);
        end
        else if (!calibrated)
            has = 1'b0;
        else
        begin
            dark = light < light_thr;
            r.rise = !dark && in_dark;
            in_dark = dark;
            unit_vector(c, u, ok);
            if (ref_dir[0] == 0 && ref_dir[1] == 0 && ref_dir[2] == 0)
                ok = 1'b0;
            if (!ok)
            begin
                r.tilt = tpc_pkg::RIGHT_ANGLE;
                r.cls  = tpc_pkg::CLASS_HEAVY;
            end
            else
            begin
                d = ref_dir[0] * u[0] + ref_dir[1] * u[1] + ref_dir[2] * u[2];
                if (d > 64'sd268435456)
                    d = 64'sd268435456;
                if (d < -64'sd268435456)
                    d = -64'sd268435456;
                ang = angle_cd(d);
                r.tilt = 15'(ang);
                if (ang < lim_up)
                    r.cls = tpc_pkg::CLASS_UPRIGHT;
                else if (ang < lim_slight)
                    r.cls = tpc_pkg::CLASS_SLIGHT;
                else if (ang < lim_mod)
                    r.cls = tpc_pkg::CLASS_MODERATE;
                else
                    r.cls = tpc_pkg::CLASS_HEAVY;
            end
            r.bad = !ok;
        end
    endtask

    task automatic report_mismatch(input string what, input posture_t exp_r,
                                   input posture_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected tilt=%0d cls=%0d light=%0d rise=%0b cal=%0b bad=%0b"
                     , what, exp_r.tilt, exp_r.cls, exp_r.light, exp_r.rise, exp_r.cal,
                     exp_r.bad);
        if (mismatches <= 10)
            $display("         actual   tilt=%0d cls=%0d light=%0d rise=%0b cal=%0b bad=%0b",
                     got.tilt, got.cls, got.light, got.rise, got.cal, got.bad);
    endtask

    always @(posedge clk)
    begin
        posture_t got;
        posture_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[14:0], m_tdata[16:15], m_tdata[28:17],
                   m_tuser[0], m_tuser[1], m_tuser[2]};
            n_out++;
            if (pending_q.size() == 0)
                report_mismatch("unexpected beat", '0, got);
            else
            begin
                exp_r = pending_q.pop_front();
                if (got !== exp_r)
                    report_mismatch("result beat", exp_r, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LONG) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tpc_pkg::REG_UPRIGHT:  lim_up     = value & 15'h7FFF;
            tpc_pkg::REG_SLIGHT:   lim_slight = value & 15'h7FFF;
            tpc_pkg::REG_MODERATE: lim_mod    = value & 15'h7FFF;
            default:               margin     = value & 12'hFFF;
        endcase
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_limits(input int unsigned up, slight, moderate, marg);
        drain_and_settle();
        reg_write(tpc_pkg::REG_UPRIGHT, up);
        reg_write(tpc_pkg::REG_SLIGHT, slight);
        reg_write(tpc_pkg::REG_MODERATE, moderate);
        reg_write(tpc_pkg::REG_MARGIN, marg);
        n_cfg++;
    endtask

    task automatic send_beat(input logic op, input logic [15:0] ax, ay, az,
                             input logic [11:0] light, input bit typed, input bit t_has,
                             input posture_t t_res);
        bit       has;
        posture_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, light, az, ay, ax};
        do
            @(posedge clk);
        while (!s_tready);
        n_in++;
        predict_posture(op, ax, ay, az, light, has, r);
        if (typed)
        begin
            has = t_has;
            r   = t_res;
        end
        if (has)
            pending_q.push_back(r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] near_axis(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic send_random();
        int unsigned pick;
        int          spread;
        logic [15:0] ax, ay, az;
        logic [11:0] light;
        pick  = $urandom_range(0, 99);
        light = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0)
            light = 12'(light_thr + $urandom_range(0, 4) - 2);
        ax = 16'($urandom_range(0, 65535));
        ay = 16'($urandom_range(0, 65535));
        az = 16'($urandom_range(0, 65535));
        if (pick < 5)
            send_beat(tpc_pkg::OP_CAL, ax, ay, az, light, 1'b0, 1'b0, '0);
        else if (pick < 9)
            send_beat(tpc_pkg::OP_MEASURE, 16'h0, 16'h0, 16'h0, light, 1'b0, 1'b0, '0);
        else if (pick < 25)
            send_beat(tpc_pkg::OP_MEASURE, ax, ay, az, light, 1'b0, 1'b0, '0);
        else
        begin
            case ($urandom_range(0, 3))
                0:       spread = 60;
                1:       spread = 600;
                2:       spread = 3000;
                default: spread = 12000;
            endcase
            ax = near_axis(cal_raw[0], spread);
            ay = near_axis(cal_raw[1], spread);
            az = near_axis(cal_raw[2], spread);
            if ($urandom_range(0, 5) == 0)
            begin
                ax = -ax;
                ay = -ay;
                az = -az;
            end
            send_beat(tpc_pkg::OP_MEASURE, ax, ay, az, light, 1'b0, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        mismatches  = 0;
        n_in        = 0;
        n_out       = 0;
        n_cfg       = 0;
        idle_cycles = 0;
        ref_dir    = '{0, 0, 0};
        cal_raw    = '{0, 0, 16384};
        light_thr  = 0;
        calibrated = 1'b0;
        in_dark    = 1'b1;
        lim_up     = 500;
        lim_slight = 800;
        lim_mod    = 1500;
        margin     = 300;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_beat(TABLE[i].op, TABLE[i].ax, TABLE[i].ay, TABLE[i].az, TABLE[i].light,
                      TABLE[i].typed, TABLE[i].has, TABLE[i].res);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_limits(500, 800, 1500, 300);
                1: set_limits(0, 0, 0, 0);
                2: set_limits(18000, 18000, 18000, 4095);
                3: set_limits(1500, 800, 500, 100);
                4: set_limits($urandom_range(0, 300), $urandom_range(300, 2000),
                              $urandom_range(2000, 18000), $urandom_range(0, 4095));
                default: set_limits(200, 1000, 6000, 50);
            endcase
            quiet = (phase == 5);
            for (int k = 0; k < 75; k++)
            begin
                if (phase == 1 && k == 20)
                    hold_req = 1'b1;
                send_random();
            end
        end

        drain_and_settle();
        if (pending_q.size() != 0)
            mismatches++;
        $display("Sent %0d input beats, checked %0d result beats under %0d limit settings,",
                 n_in, n_out, n_cfg);
        $display("including zero vectors, range extremes and a long output stall.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tpc_pkg.sv
rtl/core/tpc_isqrt.sv
rtl/core/tpc_div.sv
rtl/core/tilt_posture_classifier_top.sv
tb/tb_top.sv
